// ----- rtl/tcp_rt_pkg.sv -----
package tcp_rt_pkg;

	// Result slots allowed per scan command
	localparam int MAX_RESULTS = 8;
	localparam int RES_CNT_W   = 4;

	// Configuration reset values
	localparam logic [15:0] INITIAL_TIMEOUT_RST = 16'd50;
	localparam logic [15:0] MIN_TIMEOUT_RST     = 16'd2;
	localparam logic [15:0] MAX_TIMEOUT_RST     = 16'd200;
	localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd5;

	typedef enum logic [2:0] {
		CMD_OPEN    = 3'd0,
		CMD_ARM     = 3'd1,
		CMD_ACK     = 3'd2,
		CMD_RELEASE = 3'd3,
		CMD_SCAN    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_RETX    = 2'd1,
		EV_ABANDON = 2'd2,
		EV_SAMPLE  = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		REG_INITIAL_TIMEOUT = 2'd0,
		REG_MIN_TIMEOUT     = 2'd1,
		REG_MAX_TIMEOUT     = 2'd2,
		REG_RETRY_LIMIT     = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_ACK_RTT,
		ST_ACK_DIFF,
		ST_ACK_MAG,
		ST_ACK_SRTT_SUB,
		ST_ACK_SRTT_ADD,
		ST_ACK_VAR_SUB,
		ST_ACK_VAR_ADD,
		ST_ACK_FIRST,
		ST_ACK_SUM,
		ST_ACK_MIN,
		ST_ACK_MAX,
		ST_SCAN_CHECK,
		ST_SCAN_ELAPSED,
		ST_SCAN_DUE,
		ST_SCAN_CLAMP,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// Request to the shared adder/subtractor
	typedef struct packed {
		alu_op_t     op;
		logic [32:0] a;
		logic [32:0] b;
	} alu_req_t;

	// Per-slot record held in the slot store
	typedef struct packed {
		logic [31:0] srtt;
		logic [31:0] rttvar;
		logic [15:0] rto;
		logic [15:0] backoff;
		logic [31:0] send;
		logic [3:0]  retry;
	} rec_t;

	// Field write enables for the slot store
	typedef struct packed {
		logic srtt;
		logic rttvar;
		logic rto;
		logic backoff;
		logic send;
		logic retry;
	} store_we_t;

endpackage

// ----- rtl/tcp_rt_alu.sv -----
module tcp_rt_alu (
	input  tcp_rt_pkg::alu_req_t req,
	output logic [33:0]          y
);

	// Add or subtract; on subtract the top bit is the borrow
	always_comb begin
		unique case (req.op)
			tcp_rt_pkg::ALU_SUB: y = {1'b0, req.a} - {1'b0, req.b};
			default:             y = {1'b0, req.a} + {1'b0, req.b};
		endcase
	end

endmodule

// ----- rtl/tcp_rt_store.sv -----
module tcp_rt_store #(
	parameter int DEPTH  = 8,
	parameter int ADDR_W = 3
) (
	input  logic                  clk,
	input  logic [ADDR_W-1:0]     addr,
	input  tcp_rt_pkg::store_we_t we,
	input  tcp_rt_pkg::rec_t      wdata,
	output tcp_rt_pkg::rec_t      rdata_q
);

	logic [31:0] srtt_mem    [DEPTH];
	logic [31:0] rttvar_mem  [DEPTH];
	logic [15:0] rto_mem     [DEPTH];
	logic [15:0] backoff_mem [DEPTH];
	logic [31:0] send_mem    [DEPTH];
	logic [3:0]  retry_mem   [DEPTH];

	// Write selected fields of one slot
	always_ff @(posedge clk) begin
		if (we.srtt) begin
			srtt_mem[addr] <= wdata.srtt;
		end
		if (we.rttvar) begin
			rttvar_mem[addr] <= wdata.rttvar;
		end
		if (we.rto) begin
			rto_mem[addr] <= wdata.rto;
		end
		if (we.backoff) begin
			backoff_mem[addr] <= wdata.backoff;
		end
		if (we.send) begin
			send_mem[addr] <= wdata.send;
		end
		if (we.retry) begin
			retry_mem[addr] <= wdata.retry;
		end
	end

	// Registered read of the whole record
	always_ff @(posedge clk) begin
		rdata_q.srtt    <= srtt_mem[addr];
		rdata_q.rttvar  <= rttvar_mem[addr];
		rdata_q.rto     <= rto_mem[addr];
		rdata_q.backoff <= backoff_mem[addr];
		rdata_q.send    <= send_mem[addr];
		rdata_q.retry   <= retry_mem[addr];
	end

endmodule

// ----- rtl/tcp_retransmit_timer.sv -----
// Retransmission timer for NUM_CONNECTIONS connection slots.
// Input channel (in_valid/in_stall) carries one command transaction: cmd,
// conn_index and the current tick count now. Output channel (out_valid/
// out_stall) carries result transactions: slot, event_res, timeout_value,
// retries and last, which marks the final result of a command.
// Open, arm and release give no result and pass through accept, slot
// read and update. When ack takes an RTT sample, the sample runs as a
// chain of add/subtract steps through a single shared 33-bit adder.
// Scan checks each slot in turn and takes each pending slot through
// read, elapsed time and due test, then backoff clamp and hand-off as
// needed. One command is in flight at a time; in_stall is high until its
// results are all handed to the output register.
// Results pass through a one-entry holding register and the output
// register, so a stalled receiver only holds the sequencer at the next
// result hand-off. Reset clears all slot flags and restores the
// configuration registers; the slot record memory needs no clearing.
// Configuration is to be written by the user through the APB-style port
// while no command is in flight; the block itself does not enforce this.
module tcp_retransmit_timer #(
	parameter int NUM_CONNECTIONS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [2:0]  conn_index,
	input  logic [31:0] now,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  slot,
	output logic [1:0]  event_res,
	output logic [15:0] timeout_value,
	output logic [3:0]  retries,
	output logic        last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;
	localparam int CNT_W = $clog2(NUM_CONNECTIONS + 1);

	tcp_rt_pkg::state_t state_q, state_d;

	// configuration
	logic [15:0] init_q, min_q, max_q;
	logic [3:0]  limit_q;

	// slot flags
	logic [NUM_CONNECTIONS-1:0] active_q, awaiting_q, estval_q;

	// command context
	tcp_rt_pkg::cmd_t cmd_q;
	logic [IDX_W-1:0] cur_q;
	logic [31:0]      now_q;
	logic [CNT_W-1:0] scan_i_q;
	logic [tcp_rt_pkg::RES_CNT_W-1:0] n_q;

	// arithmetic temporaries
	logic [31:0] r_q, mag_q, sr_n_q, rv_n_q;
	logic [32:0] t_q;
	logic        borrow_q;

	// new result, holding register and output register
	logic [2:0]  new_slot_q;
	logic [1:0]  new_ev_q;
	logic [15:0] new_tv_q;
	logic [3:0]  new_rc_q;
	logic        pend_valid_q;
	logic [2:0]  pend_slot_q;
	logic [1:0]  pend_ev_q;
	logic [15:0] pend_tv_q;
	logic [3:0]  pend_rc_q;
	logic        out_valid_q;
	logic [2:0]  slot_q;
	logic [1:0]  ev_q;
	logic [15:0] tv_q;
	logic [3:0]  rc_q;
	logic        last_q;

	tcp_rt_pkg::alu_req_t  alu_req;
	logic [33:0]           alu_y;
	tcp_rt_pkg::store_we_t st_we;
	tcp_rt_pkg::rec_t      st_wdata;
	tcp_rt_pkg::rec_t      rd_q;

	logic             accept, cmd_ok, out_free, emit_go;
	logic             slot_busy, scan_done, abandon, due;
	logic [IDX_W-1:0] scan_idx;
	logic [15:0]      rto_fin, nb_fin;
	logic [31:0]      base;

	tcp_rt_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	tcp_rt_store #(
		.DEPTH  (NUM_CONNECTIONS),
		.ADDR_W (IDX_W)
	) u_store (
		.clk     (clk),
		.addr    (cur_q),
		.we      (st_we),
		.wdata   (st_wdata),
		.rdata_q (rd_q)
	);

	// Decode handshakes and per-state conditions
	assign accept    = in_valid && !in_stall;
	assign cmd_ok    = (cmd == tcp_rt_pkg::CMD_SCAN) ||
		((cmd <= tcp_rt_pkg::CMD_RELEASE) && (7'(conn_index) < 7'(NUM_CONNECTIONS)));
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_go   = !pend_valid_q || out_free;
	assign scan_idx  = scan_i_q[IDX_W-1:0];
	assign slot_busy = active_q[scan_idx] && awaiting_q[scan_idx];
	assign scan_done = (scan_i_q == CNT_W'(NUM_CONNECTIONS)) ||
		(n_q == tcp_rt_pkg::RES_CNT_W'(tcp_rt_pkg::MAX_RESULTS));
	assign abandon   = rd_q.retry >= limit_q;
	assign due       = !alu_y[33];
	assign base      = {3'b000, rd_q.srtt[31:3]};
	assign rto_fin   = alu_y[33] ? max_q : t_q[15:0];
	assign nb_fin    = alu_y[33] ? max_q : t_q[15:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcp_rt_pkg::ST_IDLE: begin
				if (accept && cmd_ok) begin
					if (cmd == tcp_rt_pkg::CMD_SCAN) begin
						state_d = tcp_rt_pkg::ST_SCAN_CHECK;
					end else begin
						state_d = tcp_rt_pkg::ST_READ;
					end
				end
			end
			tcp_rt_pkg::ST_READ: begin
				if (cmd_q == tcp_rt_pkg::CMD_SCAN) begin
					state_d = tcp_rt_pkg::ST_SCAN_ELAPSED;
				end else begin
					state_d = tcp_rt_pkg::ST_EXEC;
				end
			end
			tcp_rt_pkg::ST_EXEC: begin
				if (cmd_q == tcp_rt_pkg::CMD_ACK && active_q[cur_q] && awaiting_q[cur_q]) begin
					if (rd_q.retry != 4'd0) begin
						state_d = tcp_rt_pkg::ST_EMIT;
					end else begin
						state_d = tcp_rt_pkg::ST_ACK_RTT;
					end
				end else begin
					state_d = tcp_rt_pkg::ST_IDLE;
				end
			end
			tcp_rt_pkg::ST_ACK_RTT: begin
				if (estval_q[cur_q]) begin
					state_d = tcp_rt_pkg::ST_ACK_DIFF;
				end else begin
					state_d = tcp_rt_pkg::ST_ACK_FIRST;
				end
			end
			tcp_rt_pkg::ST_ACK_DIFF:     state_d = tcp_rt_pkg::ST_ACK_MAG;
			tcp_rt_pkg::ST_ACK_MAG:      state_d = tcp_rt_pkg::ST_ACK_SRTT_SUB;
			tcp_rt_pkg::ST_ACK_SRTT_SUB: state_d = tcp_rt_pkg::ST_ACK_SRTT_ADD;
			tcp_rt_pkg::ST_ACK_SRTT_ADD: state_d = tcp_rt_pkg::ST_ACK_VAR_SUB;
			tcp_rt_pkg::ST_ACK_VAR_SUB:  state_d = tcp_rt_pkg::ST_ACK_VAR_ADD;
			tcp_rt_pkg::ST_ACK_VAR_ADD:  state_d = tcp_rt_pkg::ST_ACK_SUM;
			tcp_rt_pkg::ST_ACK_FIRST:    state_d = tcp_rt_pkg::ST_ACK_SUM;
			tcp_rt_pkg::ST_ACK_SUM:      state_d = tcp_rt_pkg::ST_ACK_MIN;
			tcp_rt_pkg::ST_ACK_MIN:      state_d = tcp_rt_pkg::ST_ACK_MAX;
			tcp_rt_pkg::ST_ACK_MAX:      state_d = tcp_rt_pkg::ST_EMIT;
			tcp_rt_pkg::ST_SCAN_CHECK: begin
				if (scan_done) begin
					state_d = tcp_rt_pkg::ST_FLUSH;
				end else if (slot_busy) begin
					state_d = tcp_rt_pkg::ST_READ;
				end
			end
			tcp_rt_pkg::ST_SCAN_ELAPSED: state_d = tcp_rt_pkg::ST_SCAN_DUE;
			tcp_rt_pkg::ST_SCAN_DUE: begin
				if (!due) begin
					state_d = tcp_rt_pkg::ST_SCAN_CHECK;
				end else if (abandon) begin
					state_d = tcp_rt_pkg::ST_EMIT;
				end else begin
					state_d = tcp_rt_pkg::ST_SCAN_CLAMP;
				end
			end
			tcp_rt_pkg::ST_SCAN_CLAMP: state_d = tcp_rt_pkg::ST_EMIT;
			tcp_rt_pkg::ST_EMIT: begin
				if (emit_go) begin
					if (cmd_q == tcp_rt_pkg::CMD_SCAN) begin
						state_d = tcp_rt_pkg::ST_SCAN_CHECK;
					end else begin
						state_d = tcp_rt_pkg::ST_FLUSH;
					end
				end
			end
			tcp_rt_pkg::ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = tcp_rt_pkg::ST_IDLE;
				end
			end
			default: state_d = tcp_rt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: adder operands, store writes, input stall
	always_comb begin
		alu_req  = '{op: tcp_rt_pkg::ALU_ADD, a: 33'd0, b: 33'd0};
		st_we    = '0;
		st_wdata = rd_q;
		in_stall = 1'b1;
		unique case (state_q)
			tcp_rt_pkg::ST_IDLE: in_stall = 1'b0;
			tcp_rt_pkg::ST_EXEC: begin
				unique case (cmd_q)
					tcp_rt_pkg::CMD_OPEN: begin
						st_we.retry    = 1'b1;
						st_wdata.retry = 4'd0;
					end
					tcp_rt_pkg::CMD_ARM: begin
						if (active_q[cur_q]) begin
							st_we.send       = 1'b1;
							st_we.retry      = 1'b1;
							st_we.backoff    = 1'b1;
							st_wdata.send    = now_q;
							st_wdata.retry   = 4'd0;
							st_wdata.backoff = estval_q[cur_q] ? rd_q.rto : init_q;
						end
					end
					default: st_we = '0;
				endcase
			end
			tcp_rt_pkg::ST_ACK_RTT, tcp_rt_pkg::ST_SCAN_ELAPSED: begin
				alu_req = '{op: tcp_rt_pkg::ALU_SUB, a: {1'b0, now_q}, b: {1'b0, rd_q.send}};
			end
			tcp_rt_pkg::ST_ACK_DIFF: begin
				alu_req = '{op: tcp_rt_pkg::ALU_SUB, a: {1'b0, r_q}, b: {1'b0, base}};
			end
			tcp_rt_pkg::ST_ACK_MAG: begin
				alu_req = '{op: tcp_rt_pkg::ALU_SUB, a: {1'b0, base}, b: {1'b0, r_q}};
			end
			tcp_rt_pkg::ST_ACK_SRTT_SUB: begin
				alu_req = '{op: tcp_rt_pkg::ALU_SUB, a: {1'b0, rd_q.srtt}, b: {1'b0, base}};
			end
			tcp_rt_pkg::ST_ACK_SRTT_ADD: begin
				alu_req = '{op: tcp_rt_pkg::ALU_ADD, a: t_q, b: {1'b0, r_q}};
			end
			tcp_rt_pkg::ST_ACK_VAR_SUB: begin
				alu_req = '{op: tcp_rt_pkg::ALU_SUB, a: {1'b0, rd_q.rttvar},
					b: {3'b000, rd_q.rttvar[31:2]}};
			end
			tcp_rt_pkg::ST_ACK_VAR_ADD: begin
				alu_req = '{op: tcp_rt_pkg::ALU_ADD, a: t_q, b: {1'b0, mag_q}};
			end
			tcp_rt_pkg::ST_ACK_SUM: begin
				alu_req = '{op: tcp_rt_pkg::ALU_ADD, a: {4'b0000, sr_n_q[31:3]},
					b: {1'b0, rv_n_q}};
			end
			tcp_rt_pkg::ST_ACK_MIN: begin
				alu_req = '{op: tcp_rt_pkg::ALU_SUB, a: t_q, b: {17'd0, min_q}};
			end
			tcp_rt_pkg::ST_ACK_MAX: begin
				alu_req         = '{op: tcp_rt_pkg::ALU_SUB, a: {17'd0, max_q}, b: t_q};
				st_we.srtt      = 1'b1;
				st_we.rttvar    = 1'b1;
				st_we.rto       = 1'b1;
				st_wdata.srtt   = sr_n_q;
				st_wdata.rttvar = rv_n_q;
				st_wdata.rto    = rto_fin;
			end
			tcp_rt_pkg::ST_SCAN_DUE: begin
				alu_req = '{op: tcp_rt_pkg::ALU_SUB, a: t_q, b: {17'd0, rd_q.backoff}};
			end
			tcp_rt_pkg::ST_SCAN_CLAMP: begin
				alu_req          = '{op: tcp_rt_pkg::ALU_SUB, a: {17'd0, max_q}, b: t_q};
				st_we.send       = 1'b1;
				st_we.retry      = 1'b1;
				st_we.backoff    = 1'b1;
				st_wdata.send    = now_q;
				st_wdata.retry   = rd_q.retry + 4'd1;
				st_wdata.backoff = nb_fin;
			end
			default: in_stall = 1'b1;
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcp_rt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= tcp_rt_pkg::INITIAL_TIMEOUT_RST;
			min_q   <= tcp_rt_pkg::MIN_TIMEOUT_RST;
			max_q   <= tcp_rt_pkg::MAX_TIMEOUT_RST;
			limit_q <= tcp_rt_pkg::RETRY_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (tcp_rt_pkg::cfg_reg_t'(paddr[3:2]))
				tcp_rt_pkg::REG_INITIAL_TIMEOUT: init_q  <= pwdata[15:0];
				tcp_rt_pkg::REG_MIN_TIMEOUT:     min_q   <= pwdata[15:0];
				tcp_rt_pkg::REG_MAX_TIMEOUT:     max_q   <= pwdata[15:0];
				default:                         limit_q <= pwdata[3:0];
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		unique case (tcp_rt_pkg::cfg_reg_t'(paddr[3:2]))
			tcp_rt_pkg::REG_INITIAL_TIMEOUT: prdata = {16'd0, init_q};
			tcp_rt_pkg::REG_MIN_TIMEOUT:     prdata = {16'd0, min_q};
			tcp_rt_pkg::REG_MAX_TIMEOUT:     prdata = {16'd0, max_q};
			default:                         prdata = {28'd0, limit_q};
		endcase
	end

	assign pready = 1'b1;

	// Update slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			awaiting_q <= '0;
			estval_q   <= '0;
		end else begin
			if (state_q == tcp_rt_pkg::ST_EXEC) begin
				unique case (cmd_q)
					tcp_rt_pkg::CMD_OPEN: begin
						active_q[cur_q]   <= 1'b1;
						awaiting_q[cur_q] <= 1'b0;
						estval_q[cur_q]   <= 1'b0;
					end
					tcp_rt_pkg::CMD_ARM: begin
						if (active_q[cur_q]) begin
							awaiting_q[cur_q] <= 1'b1;
						end
					end
					tcp_rt_pkg::CMD_ACK: begin
						awaiting_q[cur_q] <= 1'b0;
					end
					tcp_rt_pkg::CMD_RELEASE: begin
						active_q[cur_q]   <= 1'b0;
						awaiting_q[cur_q] <= 1'b0;
					end
					default: active_q <= active_q;
				endcase
			end
			if (state_q == tcp_rt_pkg::ST_ACK_MAX) begin
				estval_q[cur_q] <= 1'b1;
			end
			if (state_q == tcp_rt_pkg::ST_SCAN_DUE && due && abandon) begin
				active_q[cur_q]   <= 1'b0;
				awaiting_q[cur_q] <= 1'b0;
			end
		end
	end

	// Track command context and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= tcp_rt_pkg::CMD_OPEN;
			cur_q    <= '0;
			scan_i_q <= '0;
			n_q      <= '0;
		end else begin
			unique case (state_q)
				tcp_rt_pkg::ST_IDLE: begin
					if (accept) begin
						cmd_q    <= tcp_rt_pkg::cmd_t'(cmd);
						cur_q    <= IDX_W'(conn_index);
						scan_i_q <= '0;
						n_q      <= '0;
					end
				end
				tcp_rt_pkg::ST_SCAN_CHECK: begin
					if (!scan_done) begin
						if (slot_busy) begin
							cur_q <= scan_idx;
						end else begin
							scan_i_q <= scan_i_q + CNT_W'(1);
						end
					end
				end
				tcp_rt_pkg::ST_SCAN_DUE: begin
					if (!due) begin
						scan_i_q <= scan_i_q + CNT_W'(1);
					end
				end
				tcp_rt_pkg::ST_EMIT: begin
					if (emit_go) begin
						scan_i_q <= scan_i_q + CNT_W'(1);
						n_q      <= n_q + tcp_rt_pkg::RES_CNT_W'(1);
					end
				end
				default: cur_q <= cur_q;
			endcase
		end
	end

	// Capture now with the command
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now;
		end
	end

	// Arithmetic temporaries and new result
	always_ff @(posedge clk) begin
		unique case (state_q)
			tcp_rt_pkg::ST_EXEC: begin
				new_slot_q <= 3'(cur_q);
				new_ev_q   <= tcp_rt_pkg::EV_NONE;
				new_tv_q   <= 16'd0;
				new_rc_q   <= rd_q.retry;
			end
			tcp_rt_pkg::ST_ACK_RTT: begin
				r_q <= (alu_y[31:0] == 32'd0) ? 32'd1 : alu_y[31:0];
			end
			tcp_rt_pkg::ST_ACK_DIFF: begin
				mag_q    <= alu_y[31:0];
				borrow_q <= alu_y[33];
			end
			tcp_rt_pkg::ST_ACK_MAG: begin
				if (borrow_q) begin
					mag_q <= alu_y[31:0];
				end
			end
			tcp_rt_pkg::ST_ACK_SRTT_SUB, tcp_rt_pkg::ST_ACK_VAR_SUB,
			tcp_rt_pkg::ST_SCAN_ELAPSED: begin
				t_q <= {1'b0, alu_y[31:0]};
			end
			tcp_rt_pkg::ST_ACK_SRTT_ADD: begin
				sr_n_q <= (alu_y[33:32] != 2'b00) ? 32'hFFFF_FFFF : alu_y[31:0];
			end
			tcp_rt_pkg::ST_ACK_VAR_ADD: begin
				rv_n_q <= (alu_y[33:32] != 2'b00) ? 32'hFFFF_FFFF : alu_y[31:0];
			end
			tcp_rt_pkg::ST_ACK_FIRST: begin
				sr_n_q <= (r_q[31:29] != 3'b000) ? 32'hFFFF_FFFF : {r_q[28:0], 3'b000};
				rv_n_q <= r_q[31] ? 32'hFFFF_FFFF : {r_q[30:0], 1'b0};
			end
			tcp_rt_pkg::ST_ACK_SUM: begin
				t_q <= alu_y[32:0];
			end
			tcp_rt_pkg::ST_ACK_MIN: begin
				if (alu_y[33]) begin
					t_q <= {17'd0, min_q};
				end
			end
			tcp_rt_pkg::ST_ACK_MAX: begin
				new_slot_q <= 3'(cur_q);
				new_ev_q   <= tcp_rt_pkg::EV_SAMPLE;
				new_tv_q   <= rto_fin;
				new_rc_q   <= 4'd0;
			end
			tcp_rt_pkg::ST_SCAN_DUE: begin
				t_q        <= {16'd0, rd_q.backoff, 1'b0};
				new_slot_q <= 3'(cur_q);
				new_ev_q   <= tcp_rt_pkg::EV_ABANDON;
				new_tv_q   <= 16'd0;
				new_rc_q   <= rd_q.retry;
			end
			tcp_rt_pkg::ST_SCAN_CLAMP: begin
				new_ev_q <= tcp_rt_pkg::EV_RETX;
				new_tv_q <= nb_fin;
				new_rc_q <= rd_q.retry + 4'd1;
			end
			default: borrow_q <= borrow_q;
		endcase
	end

	// Hold the newest result until the next one or the end of the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (state_q == tcp_rt_pkg::ST_EMIT && emit_go) begin
			pend_valid_q <= 1'b1;
		end else if (state_q == tcp_rt_pkg::ST_FLUSH && out_free) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcp_rt_pkg::ST_EMIT && emit_go) begin
			pend_slot_q <= new_slot_q;
			pend_ev_q   <= new_ev_q;
			pend_tv_q   <= new_tv_q;
			pend_rc_q   <= new_rc_q;
		end
	end

	// Load the output register from the holding register
	logic out_load, out_last;
	assign out_load = pend_valid_q && out_free &&
		((state_q == tcp_rt_pkg::ST_EMIT) || (state_q == tcp_rt_pkg::ST_FLUSH));
	assign out_last = (state_q == tcp_rt_pkg::ST_FLUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_q <= pend_slot_q;
			ev_q   <= pend_ev_q;
			tv_q   <= pend_tv_q;
			rc_q   <= pend_rc_q;
			last_q <= out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign slot          = slot_q;
	assign event_res     = ev_q;
	assign timeout_value = tv_q;
	assign retries       = rc_q;
	assign last          = last_q;

endmodule

// ----- dv/tb_tcp_retransmit_timer.sv -----
module tb_tcp_retransmit_timer;
	import tcp_rt_pkg::*;

	localparam int NCONN = 8;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 64;

	// one result transaction as seen on the result channel
	typedef struct packed {
		logic [2:0]  slot;
		ev_t         ev;
		logic [15:0] tmo;
		logic [3:0]  rc;
		logic        last;
	} timer_event_t;

	// one command of the directed sequence; want is used when typed is set
	typedef struct packed {
		logic [2:0]   op;
		logic [2:0]   idx;
		logic [31:0]  t;
		logic         typed;
		timer_event_t want;
	} stim_row_t;

	localparam timer_event_t NO_EVT = '0;

	localparam stim_row_t DIR_ROWS [26] = '{
		'{CMD_OPEN,    3'd0, 32'd0,          1'b0, NO_EVT},
		'{CMD_ACK,     3'd0, 32'd0,          1'b0, NO_EVT},
		'{CMD_ARM,     3'd0, 32'd100,        1'b0, NO_EVT},
		'{CMD_ACK,     3'd0, 32'd110,        1'b1, '{3'd0, EV_SAMPLE, 16'd30, 4'd0, 1'b1}},
		'{CMD_OPEN,    3'd1, 32'd0,          1'b0, NO_EVT},
		'{CMD_ARM,     3'd1, 32'd0,          1'b0, NO_EVT},
		'{CMD_ACK,     3'd1, 32'hFFFF_FFFF,  1'b1, '{3'd1, EV_SAMPLE, 16'd200, 4'd0, 1'b1}},
		'{CMD_OPEN,    3'd2, 32'd0,          1'b0, NO_EVT},
		'{CMD_ARM,     3'd2, 32'd1000,       1'b0, NO_EVT},
		'{CMD_SCAN,    3'd0, 32'd1049,       1'b0, NO_EVT},
		'{CMD_SCAN,    3'd5, 32'd1050,       1'b1, '{3'd2, EV_RETX, 16'd100, 4'd1, 1'b1}},
		'{CMD_ACK,     3'd2, 32'd1060,       1'b1, '{3'd2, EV_NONE, 16'd0, 4'd1, 1'b1}},
		'{CMD_OPEN,    3'd3, 32'd0,          1'b0, NO_EVT},
		'{CMD_ARM,     3'd3, 32'hFFFF_FFF0,  1'b0, NO_EVT},
		'{CMD_SCAN,    3'd7, 32'h0000_0022,  1'b1, '{3'd3, EV_RETX, 16'd100, 4'd1, 1'b1}},
		'{CMD_ARM,     3'd3, 32'd5,          1'b0, NO_EVT},
		'{CMD_ACK,     3'd3, 32'd5,          1'b1, '{3'd3, EV_SAMPLE, 16'd3, 4'd0, 1'b1}},
		'{CMD_ARM,     3'd0, 32'd200,        1'b0, NO_EVT},
		'{CMD_ACK,     3'd0, 32'd300,        1'b0, NO_EVT},
		'{CMD_RELEASE, 3'd1, 32'd0,          1'b0, NO_EVT},
		'{CMD_ARM,     3'd1, 32'd7,          1'b0, NO_EVT},
		'{CMD_ACK,     3'd1, 32'd9,          1'b0, NO_EVT},
		'{CMD_UNUSED,  3'd0, 32'd11,         1'b0, NO_EVT},
		'{CMD_OPEN,    3'd7, 32'd0,          1'b0, NO_EVT},
		'{CMD_ARM,     3'd7, 32'hFFFF_FFFF,  1'b0, NO_EVT},
		'{CMD_SCAN,    3'd0, 32'd0,          1'b0, NO_EVT}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [2:0]  conn_index;
	logic [31:0] now;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  slot;
	logic [1:0]  event_res;
	logic [15:0] timeout_value;
	logic [3:0]  retries;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// shadow copy of the timer state and registers
	logic [15:0] cfg_init;
	logic [15:0] cfg_min;
	logic [15:0] cfg_max;
	logic [3:0]  cfg_limit;
	bit          slot_active  [NCONN];
	bit          slot_waiting [NCONN];
	bit          est_valid    [NCONN];
	logic [31:0] srtt_x8      [NCONN];
	logic [31:0] rttvar_x4    [NCONN];
	logic [15:0] rto_est      [NCONN];
	logic [15:0] backoff      [NCONN];
	logic [31:0] send_at      [NCONN];
	logic [3:0]  retry_cnt    [NCONN];

	timer_event_t step_out [MAX_RESULTS];
	timer_event_t timer_events_q [$];
	timer_event_t head;
	int          mismatch_cnt;
	bit          steady;
	logic [31:0] clock_now;

	tcp_retransmit_timer #(.NUM_CONNECTIONS(NCONN)) u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		mismatch_cnt++;
	endtask

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// take an RTT sample for slot s and return the clamped timeout estimate
	function automatic logic [15:0] sample_rtt(input int s, input logic [31:0] t);
		logic [31:0] el;
		logic [63:0] r, sr, rv, base, mag, rto;
		el = t - send_at[s];
		r = (el == 32'd0) ? 64'd1 : {32'd0, el};
		if (!est_valid[s]) begin
			srtt_x8[s] = sat32(r << 3);
			rttvar_x4[s] = sat32(r << 1);
			est_valid[s] = 1'b1;
		end else begin
			sr = {32'd0, srtt_x8[s]};
			rv = {32'd0, rttvar_x4[s]};
			base = sr >> 3;
			mag = (r >= base) ? r - base : base - r;
			srtt_x8[s] = sat32(sr - base + r);
			rttvar_x4[s] = sat32(rv - (rv >> 2) + mag);
		end
		rto = ({32'd0, srtt_x8[s]} >> 3) + {32'd0, rttvar_x4[s]};
		if (rto < {48'd0, cfg_min})
			rto = {48'd0, cfg_min};
		if (rto > {48'd0, cfg_max})
			rto = {48'd0, cfg_max};
		rto_est[s] = rto[15:0];
		return rto[15:0];
	endfunction

	// advance the shadow state by one command; fill step_out, return the
	// number of results, or -1 when the block ignores the command
	function automatic int timer_step(input logic [2:0] op, input logic [2:0] s,
	                                  input logic [31:0] t);
		int n;
		logic [31:0] el;
		logic [16:0] dbl;
		n = 0;
		case (op)
			CMD_SCAN: begin
				for (int i = 0; i < NCONN && n < MAX_RESULTS; i++) begin
					el = t - send_at[i];
					if (slot_active[i] && slot_waiting[i] && el >= {16'd0, backoff[i]}) begin
						if (retry_cnt[i] >= cfg_limit) begin
							slot_active[i] = 1'b0;
							slot_waiting[i] = 1'b0;
							step_out[n] = '{3'(i), EV_ABANDON, 16'd0, retry_cnt[i], 1'b0};
						end else begin
							send_at[i] = t;
							retry_cnt[i] = retry_cnt[i] + 4'd1;
							dbl = {backoff[i], 1'b0};
							backoff[i] = (dbl > {1'b0, cfg_max}) ? cfg_max : dbl[15:0];
							step_out[n] = '{3'(i), EV_RETX, backoff[i], retry_cnt[i], 1'b0};
						end
						n++;
					end
				end
			end
			CMD_OPEN: begin
				slot_active[s] = 1'b1;
				slot_waiting[s] = 1'b0;
				est_valid[s] = 1'b0;
				retry_cnt[s] = 4'd0;
			end
			CMD_ARM: begin
				if (!slot_active[s])
					return -1;
				slot_waiting[s] = 1'b1;
				send_at[s] = t;
				retry_cnt[s] = 4'd0;
				backoff[s] = est_valid[s] ? rto_est[s] : cfg_init;
			end
			CMD_ACK: begin
				if (!(slot_active[s] && slot_waiting[s]))
					return -1;
				if (retry_cnt[s] == 4'd0)
					step_out[0] = '{s, EV_SAMPLE, sample_rtt(s, t), 4'd0, 1'b0};
				else
					step_out[0] = '{s, EV_NONE, 16'd0, retry_cnt[s], 1'b0};
				slot_waiting[s] = 1'b0;
				n = 1;
			end
			CMD_RELEASE: begin
				slot_active[s] = 1'b0;
				slot_waiting[s] = 1'b0;
			end
			default: return -1;
		endcase
		if (n > 0)
			step_out[n - 1].last = 1'b1;
		return n;
	endfunction

	// send one command transaction and record what it should produce
	task automatic issue_cmd(input logic [2:0] op, input logic [2:0] idx,
	                         input logic [31:0] t, input bit typed,
	                         input timer_event_t want, output bit acted);
		int n;
		while (!steady && $urandom_range(99) < 23) begin
			@(negedge clk);
			in_valid <= 1'b0;
			cmd <= 3'($urandom);
			now <= $urandom;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= op;
		conn_index <= idx;
		now <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n = timer_step(op, idx, t);
		if (typed) begin
			timer_events_q.push_back(want);
		end else begin
			for (int k = 0; k < n; k++)
				timer_events_q.push_back(step_out[k]);
		end
		acted = (n >= 0);
	endtask

	// hold off the sender until every pending result has arrived, then settle
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (timer_events_q.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (timer_events_q.size() > 0) begin
			report_mismatch("results never arrived", timer_events_q.size(), 0);
			timer_events_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write one register, then read it back
	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		logic [15:0] mask;
		mask = (r == REG_RETRY_LIMIT) ? 16'h000F : 16'hFFFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if ((prdata[15:0] & mask) !== (v & mask))
			report_mismatch("register readback", prdata, v & mask);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (r)
			REG_INITIAL_TIMEOUT: cfg_init = v;
			REG_MIN_TIMEOUT:     cfg_min = v;
			REG_MAX_TIMEOUT:     cfg_max = v;
			default:             cfg_limit = v[3:0];
		endcase
	endtask

	task automatic set_timer_config(input logic [15:0] init_t, input logic [15:0] min_t,
	                                input logic [15:0] max_t, input logic [3:0] limit);
		drain_results();
		write_reg(REG_INITIAL_TIMEOUT, init_t);
		write_reg(REG_MIN_TIMEOUT, min_t);
		write_reg(REG_MAX_TIMEOUT, max_t);
		write_reg(REG_RETRY_LIMIT, {12'd0, limit});
	endtask

	// mostly open/arm/ack lifecycles on random slots, with scans and noise
	task automatic run_random(input int items, input int span);
		int done;
		int r;
		bit acted;
		logic [2:0] s;
		logic [2:0] op;
		done = 0;
		while (done < items) begin
			r = $urandom_range(99);
			s = 3'($urandom_range(NCONN - 1));
			if ($urandom_range(49) == 0)
				clock_now = $urandom;
			else
				clock_now = clock_now + $urandom_range(span);
			if (r < 8)
				op = 3'($urandom_range(7));
			else if (r < 38)
				op = CMD_SCAN;
			else if (!slot_active[s])
				op = ($urandom_range(9) == 0) ? CMD_RELEASE : CMD_OPEN;
			else if (!slot_waiting[s])
				op = ($urandom_range(9) == 0) ? CMD_RELEASE : CMD_ARM;
			else begin
				r = $urandom_range(99);
				op = (r < 70) ? CMD_ACK : (r < 85) ? CMD_ARM : (r < 95) ? CMD_RELEASE : CMD_OPEN;
			end
			issue_cmd(op, s, clock_now, 1'b0, NO_EVT, acted);
			if (acted)
				done++;
		end
	endtask

	// receiver stalls at random outside the steady stretch
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 23);
	end

	// compare each result transaction with the oldest pending one
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (timer_events_q.size() == 0) begin
				report_mismatch("result with nothing pending, slot", slot, 0);
			end else begin
				head = timer_events_q.pop_front();
				if (slot !== head.slot)
					report_mismatch("slot", slot, head.slot);
				if (event_res !== head.ev)
					report_mismatch("event_res", event_res, head.ev);
				if (timeout_value !== head.tmo)
					report_mismatch("timeout_value", timeout_value, head.tmo);
				if (retries !== head.rc)
					report_mismatch("retries", retries, head.rc);
				if (last !== head.last)
					report_mismatch("last", last, head.last);
			end
		end
	end

	initial begin
		bit acted;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_OPEN;
		conn_index = 3'd0;
		now = 32'd0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 32'd0;
		mismatch_cnt = 0;
		steady = 1'b0;
		cfg_init = INITIAL_TIMEOUT_RST;
		cfg_min = MIN_TIMEOUT_RST;
		cfg_max = MAX_TIMEOUT_RST;
		cfg_limit = RETRY_LIMIT_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed sequence at reset values
		foreach (DIR_ROWS[i])
			issue_cmd(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].t,
			          DIR_ROWS[i].typed, DIR_ROWS[i].want, acted);
		clock_now = 32'd2000;
		run_random(40, 40);

		// smallest timeouts, no retries allowed
		set_timer_config(16'd1, 16'd1, 16'd1, 4'd0);
		run_random(35, 3);

		// largest timeouts and retry limit, with one full pause midway
		set_timer_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
		run_random(18, 30000);
		drain_results();
		run_random(17, 30000);

		// lower clamp above upper clamp
		set_timer_config(16'd3, 16'd10, 16'd5, 4'd2);
		run_random(35, 12);

		// random settings, first half with no idling on either side
		set_timer_config(16'($urandom_range(60, 1)), 16'($urandom_range(10, 1)),
		                 16'($urandom_range(150, 10)), 4'($urandom_range(6)));
		steady = 1'b1;
		run_random(20, 50);
		steady = 1'b0;
		run_random(20, 50);

		drain_results();
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tcp_rt_pkg.sv
rtl/tcp_rt_alu.sv
rtl/tcp_rt_store.sv
rtl/tcp_retransmit_timer.sv
dv/tb_tcp_retransmit_timer.sv
